// ----- hdl/dtmf_tone_pair_detector_defines.svh -----
// Assertion macros used by the detector top level.
`ifndef DTMF_TONE_PAIR_DETECTOR_DEFINES_SVH
`define DTMF_TONE_PAIR_DETECTOR_DEFINES_SVH

// Concurrent assertion with an explicit clock and active-low reset.
`define DTPD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define DTPD_ASSERT(label, prop, msg) \
  `DTPD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/dtmf_tpd_pkg.sv -----
package dtmf_tpd_pkg;

  localparam int unsigned NumTones  = 7;
  localparam int unsigned NumRows   = 4;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned SumW      = 19;  // five levels of 16 bits
  localparam int unsigned GainW     = 4;
  localparam int unsigned LimitW    = SumW + GainW;
  localparam int unsigned ToneW     = 3;

  localparam logic [GainW-1:0] GainReset = 4'd4;
  localparam logic [ToneW-1:0] FirstCol  = 3'd4;

  typedef struct packed {
    logic [LevelW-1:0] level_697;
    logic [LevelW-1:0] level_770;
    logic [LevelW-1:0] level_852;
    logic [LevelW-1:0] level_941;
    logic [LevelW-1:0] level_1209;
    logic [LevelW-1:0] level_1336;
    logic [LevelW-1:0] level_1477;
  } in_t;

  typedef struct packed {
    logic [6:0] key_char;
    logic [1:0] key_row;
    logic [1:0] key_col;
  } out_t;

  // Summary of the matching tones in one frame.
  typedef struct packed {
    logic             two;     // exactly two matches
    logic             below2;  // fewer than two matches
    logic [ToneW-1:0] m0;
    logic [ToneW-1:0] m1;
  } match_t;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhSeen1  = 6'b000010,
    PhSeen2  = 6'b000100,
    PhHeld   = 6'b001000,
    PhQuiet1 = 6'b010000,
    PhQuiet2 = 6'b100000
  } phase_e;

  typedef logic [LevelW-1:0] levels_t [NumTones];

  function automatic levels_t unpack_levels(in_t d);
    levels_t lv;
    lv[0] = d.level_697;
    lv[1] = d.level_770;
    lv[2] = d.level_852;
    lv[3] = d.level_941;
    lv[4] = d.level_1209;
    lv[5] = d.level_1336;
    lv[6] = d.level_1477;
    return lv;
  endfunction

  // ASCII of the key at a keypad position.
  function automatic logic [6:0] key_lookup(logic [1:0] row, logic [1:0] col);
    logic [6:0] c;
    case ({row, col})
      4'b00_00: c = 7'h31;
      4'b00_01: c = 7'h32;
      4'b00_10: c = 7'h33;
      4'b01_00: c = 7'h34;
      4'b01_01: c = 7'h35;
      4'b01_10: c = 7'h36;
      4'b10_00: c = 7'h37;
      4'b10_01: c = 7'h38;
      4'b10_10: c = 7'h39;
      4'b11_00: c = 7'h2a;
      4'b11_01: c = 7'h30;
      4'b11_10: c = 7'h23;
      default:  c = 7'h31;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/dtmf_tone_pair_detector.sv -----
// DTMF tone-pair detector.
// Input channel (in_valid_i/in_ready_o/in_data_i): one analysis frame per
// transaction, seven noise-normalized tone levels from 697 to 1477 Hz.
// Output channel (out_valid_o/out_ready_i/out_data_o): one key per
// transaction (ASCII, row index, column index); most frames produce none.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): threshold gain,
// always ready; write it only while no frame is in flight.
// Pipeline: input register, floor register, result register. A frame moves
// through them in that order; its key, if any, drives out_data_o.
// Throughput is one frame per cycle unless out_ready_i stalls; the critical
// path is the top-two search over seven levels, or gain multiply plus compare.
// A key is emitted on the frame right after two quiet frames, which in
// turn follow a pair held for three frames.
// Reset clears the pipeline, the debouncer (idle, no stored pair) and sets
// the gain to 4. When the receiver stalls, the result register holds and up
// to two more frames fill the input and floor registers before in_ready_o drops.
`include "dtmf_tone_pair_detector_defines.svh"

module dtmf_tone_pair_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dtmf_tpd_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dtmf_tpd_pkg::out_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dtmf_tpd_pkg::GainW-1:0]      cfg_data_i
);

  logic [dtmf_tpd_pkg::GainW-1:0] gain_q;

  logic                          s1_valid_q, s2_valid_q, out_valid_q;
  dtmf_tpd_pkg::in_t             s1_data_q, s2_data_q;
  logic [dtmf_tpd_pkg::SumW-1:0] sum5, s2_sum5_q;
  dtmf_tpd_pkg::out_t            out_data_q;

  logic out_free, s2_fire, s2_ready, s1_move, in_fire;
  logic res_valid;
  dtmf_tpd_pkg::match_t match;
  dtmf_tpd_pkg::out_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= dtmf_tpd_pkg::GainReset;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_fire    = s2_valid_q && out_free;
  assign s2_ready   = !s2_valid_q || s2_fire;
  assign s1_move    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  dtmf_tpd_floor u_floor (
    .frame_i (s1_data_q),
    .sum5_o  (sum5)
  );

  dtmf_tpd_match u_match (
    .frame_i (s2_data_q),
    .sum5_i  (s2_sum5_q),
    .gain_i  (gain_q),
    .match_o (match)
  );

  dtmf_tpd_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s2_fire),
    .match_i     (match),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_fire) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_move) begin
      s2_data_q <= s1_data_q;
      s2_sum5_q <= sum5;
    end
    if (s2_fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `DTPD_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |-> !s2_fire,
               "debouncer advanced while a result was stalled")
  `DTPD_ASSERT(a_empty_ready, !s1_valid_q |-> in_ready_o,
               "input stage empty but not ready")
  `DTPD_ASSERT(a_col_range, out_valid_o |-> (out_data_o.key_col != 2'd3),
               "column index out of range")

endmodule

// ----- hdl/dtmf_tpd_floor.sv -----
// Sum of the five smallest levels: total minus the two largest.
module dtmf_tpd_floor (
  input  dtmf_tpd_pkg::in_t              frame_i,
  output logic [dtmf_tpd_pkg::SumW-1:0]  sum5_o
);

  dtmf_tpd_pkg::levels_t lv;
  logic [dtmf_tpd_pkg::LevelW-1:0] big1, big2;
  logic [dtmf_tpd_pkg::SumW-1:0]   total;

  assign lv = dtmf_tpd_pkg::unpack_levels(frame_i);

  always_comb begin
    big1  = '0;
    big2  = '0;
    total = '0;
    for (int i = 0; i < dtmf_tpd_pkg::NumTones; i++) begin
      total = total + dtmf_tpd_pkg::SumW'(lv[i]);
      if (lv[i] > big1) begin
        big2 = big1;
        big1 = lv[i];
      end else if (lv[i] > big2) begin
        big2 = lv[i];
      end
    end
  end

  assign sum5_o = total - dtmf_tpd_pkg::SumW'(big1) - dtmf_tpd_pkg::SumW'(big2);

endmodule

// ----- hdl/dtmf_tpd_match.sv -----
// Scale the floor by the gain and find the tones strictly above it.
module dtmf_tpd_match (
  input  dtmf_tpd_pkg::in_t               frame_i,
  input  logic [dtmf_tpd_pkg::SumW-1:0]   sum5_i,
  input  logic [dtmf_tpd_pkg::GainW-1:0]  gain_i,
  output dtmf_tpd_pkg::match_t            match_o
);

  dtmf_tpd_pkg::levels_t lv;
  logic [dtmf_tpd_pkg::LimitW-1:0] limit;
  logic [1:0]                      cnt;
  logic [dtmf_tpd_pkg::ToneW-1:0]  m0, m1;
  logic                            many;

  assign lv    = dtmf_tpd_pkg::unpack_levels(frame_i);
  assign limit = dtmf_tpd_pkg::LimitW'(sum5_i) * dtmf_tpd_pkg::LimitW'(gain_i);

  always_comb begin
    cnt  = '0;
    m0   = '0;
    m1   = '0;
    many = 1'b0;
    for (int i = 0; i < dtmf_tpd_pkg::NumTones; i++) begin
      if (dtmf_tpd_pkg::LimitW'(lv[i]) > limit) begin
        if (cnt == 2'd0) begin
          m0 = dtmf_tpd_pkg::ToneW'(i);
        end else if (cnt == 2'd1) begin
          m1 = dtmf_tpd_pkg::ToneW'(i);
        end
        if (cnt == 2'd2) begin
          many = 1'b1;
        end else begin
          cnt = cnt + 2'd1;
        end
      end
    end
  end

  assign match_o.two    = (cnt == 2'd2) && !many;
  assign match_o.below2 = (cnt < 2'd2);
  assign match_o.m0     = m0;
  assign match_o.m1     = m1;

endmodule

// ----- hdl/dtmf_tpd_debounce.sv -----
// Frame debouncer: pair seen in three frames, two quiet frames, then emit.
module dtmf_tpd_debounce (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  dtmf_tpd_pkg::match_t match_i,
  output logic                 res_valid_o,
  output dtmf_tpd_pkg::out_t   res_o
);

  dtmf_tpd_pkg::phase_e phase_q, phase_d;
  logic [dtmf_tpd_pkg::ToneW-1:0] first_q, first_d, second_q, second_d;
  logic same, row_col, col_row;
  logic [1:0] row, col;

  assign same = match_i.two && (match_i.m0 == first_q) && (match_i.m1 == second_q);

  assign row_col = (first_q < dtmf_tpd_pkg::FirstCol) && (second_q >= dtmf_tpd_pkg::FirstCol);
  assign col_row = (first_q >= dtmf_tpd_pkg::FirstCol) && (second_q < dtmf_tpd_pkg::FirstCol);

  always_comb begin
    if (row_col) begin
      row = first_q[1:0];
      col = 2'(second_q - dtmf_tpd_pkg::FirstCol);
    end else begin
      row = second_q[1:0];
      col = 2'(first_q - dtmf_tpd_pkg::FirstCol);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    second_d    = second_q;
    res_valid_o = 1'b0;
    case (phase_q)
      dtmf_tpd_pkg::PhSeen1:  phase_d = same ? dtmf_tpd_pkg::PhSeen2 : dtmf_tpd_pkg::PhIdle;
      dtmf_tpd_pkg::PhSeen2:  phase_d = same ? dtmf_tpd_pkg::PhHeld : dtmf_tpd_pkg::PhIdle;
      dtmf_tpd_pkg::PhHeld:   phase_d = match_i.below2 ? dtmf_tpd_pkg::PhQuiet1
                                                       : dtmf_tpd_pkg::PhHeld;
      dtmf_tpd_pkg::PhQuiet1: phase_d = match_i.below2 ? dtmf_tpd_pkg::PhQuiet2
                                                       : dtmf_tpd_pkg::PhIdle;
      dtmf_tpd_pkg::PhQuiet2: begin
        phase_d     = dtmf_tpd_pkg::PhIdle;
        res_valid_o = fire_i && (row_col || col_row);
      end
      default: begin
        // idle: latch a fresh pair
        if (match_i.two) begin
          first_d  = match_i.m0;
          second_d = match_i.m1;
          phase_d  = dtmf_tpd_pkg::PhSeen1;
        end else begin
          phase_d = dtmf_tpd_pkg::PhIdle;
        end
      end
    endcase
  end

  assign res_o.key_char = dtmf_tpd_pkg::key_lookup(row, col);
  assign res_o.key_row  = row;
  assign res_o.key_col  = col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dtmf_tpd_pkg::PhIdle;
      first_q  <= '0;
      second_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule
